/* hdl/q2e_pkg.sv */
`default_nettype none
package q2e_pkg;

  // Width of the CORDIC x/y datapath (sums reach about 2^33, gain 1.65)
  localparam int XW = 38;
  // Width of the sine/cosine terms in units of 2^-30
  localparam int TW = 36;
  // Square root datapath width (radicand up to 2^60)
  localparam int SQW = 61;
  // One cell per result bit of the square root
  localparam int SQRT_CELLS = 31;

  // atan(2^-i) on a 2^32 full-turn scale
  localparam logic [31:0] ATAN_TURN32 [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Terms carried alongside the square root chain
  typedef struct packed {
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sp;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic                 sat_pos;
    logic                 sat_neg;
  } side_t;

  // Rotation angle of one CORDIC step, rounded to the phase scale
  function automatic logic [31:0] atan_step(input int idx, input int ab);
    logic [32:0] t;
    logic [32:0] r;
    t = {1'b0, ATAN_TURN32[idx]};
    if (ab >= 32) begin
      r = t;
    end else begin
      r = (t + (33'd1 << (31 - ab))) >> (32 - ab);
    end
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/q2e_sqrt_cell.sv */
`default_nettype none
// One bit of the restoring integer square root
module q2e_sqrt_cell #(
  parameter int K = 0
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [q2e_pkg::SQW-1:0]    v_in,
  input  wire logic [q2e_pkg::SQW-1:0]    r_in,
  output logic      [q2e_pkg::SQW-1:0]    v_out,
  output logic      [q2e_pkg::SQW-1:0]    r_out
);

  localparam logic [q2e_pkg::SQW-1:0] BIT = {{(q2e_pkg::SQW-1){1'b0}}, 1'b1} << (60 - 2*K);

  logic [q2e_pkg::SQW-1:0] trial;

  assign trial = r_in + BIT;

  // Subtract the trial value where it fits, shift the root
  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= trial) begin
        v_out <= v_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/q2e_cordic_cell.sv */
`default_nettype none
// One vectoring CORDIC micro-rotation
module q2e_cordic_cell #(
  parameter int ANGLE_BITS = 16,
  parameter int IDX        = 0
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [q2e_pkg::XW-1:0]  x_in,
  input  wire logic signed [q2e_pkg::XW-1:0]  y_in,
  input  wire logic        [ANGLE_BITS-1:0]   z_in,
  output logic signed      [q2e_pkg::XW-1:0]  x_out,
  output logic signed      [q2e_pkg::XW-1:0]  y_out,
  output logic             [ANGLE_BITS-1:0]   z_out
);

  localparam logic [31:0] STEP = q2e_pkg::atan_step(IDX, ANGLE_BITS);

  logic signed [q2e_pkg::XW-1:0] dx;
  logic signed [q2e_pkg::XW-1:0] dy;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  // Rotate toward y = 0, accumulate the phase
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[q2e_pkg::XW-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + STEP[ANGLE_BITS-1:0];
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - STEP[ANGLE_BITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/quaternion_to_euler_unit.sv */
`default_nettype none
// Channel  | direction | tdata (low bit up)                         | tuser
// s_axis   | in        | quat_w, quat_x, quat_y, quat_z (64 bits)   | -
// m_axis   | out       | roll_angle, pitch_angle, yaw_angle (48)    | pitch_clamped
//
// One quaternion per cycle while the output is not stalled; data runs through
// the 31-cell square root chain followed by the CORDIC cell row.
// rst clears the valid bits of every stage; payload registers are not reset.
// When the output holds a transaction that is not taken, the whole pipeline
// freezes and s_tready drops; every stage advances again once it is taken.
module quaternion_to_euler_unit #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic             m_tuser    // pitch_clamped
);

  localparam int XW  = q2e_pkg::XW;
  localparam int TW  = q2e_pkg::TW;
  localparam int SQW = q2e_pkg::SQW;
  localparam int NSQ = q2e_pkg::SQRT_CELLS;
  localparam int L   = 36 + CORDIC_STAGES;
  localparam logic [ANGLE_BITS-1:0] QUARTER =
    {{(ANGLE_BITS-1){1'b0}}, 1'b1} << (ANGLE_BITS - 2);
  localparam logic signed [TW-1:0] ONE_Q30 = {{(TW-1){1'b0}}, 1'b1} << 30;

  logic en;
  logic vld [0:L-1];

  assign en       = !vld[L-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[L-1];

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < L; i++) vld[i] <= vld[i-1];
    end
  end

  // Products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
    end
  end

  // Sine and cosine terms, pitch saturation
  q2e_pkg::side_t side [0:NSQ+1];
  logic signed [TW-1:0] t_sr, t_cr, t_sp, t_sy, t_cy;

  always_comb begin
    t_sr = (TW'(p_wx) + TW'(p_yz)) <<< 1;
    t_cr = ONE_Q30 - ((TW'(p_xx) + TW'(p_yy)) <<< 1);
    t_sp = (TW'(p_wy) - TW'(p_zx)) <<< 1;
    t_sy = (TW'(p_wz) + TW'(p_xy)) <<< 1;
    t_cy = ONE_Q30 - ((TW'(p_yy) + TW'(p_zz)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].sr      <= t_sr;
      side[0].cr      <= t_cr;
      side[0].sp      <= t_sp;
      side[0].sy      <= t_sy;
      side[0].cy      <= t_cy;
      side[0].sat_pos <= t_sp >= ONE_Q30;
      side[0].sat_neg <= t_sp <= -ONE_Q30;
      for (int i = 1; i <= NSQ + 1; i++) side[i] <= side[i-1];
    end
  end

  // Square of the pitch sine term (only meaningful below saturation)
  logic signed [30:0] sp_lo;
  logic        [61:0] s2;

  assign sp_lo = side[0].sp[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= 62'(sp_lo * sp_lo);
    end
  end

  // Square root chain of 1 - s^2
  logic [SQW-1:0] sq_v [0:NSQ];
  logic [SQW-1:0] sq_r [0:NSQ];

  assign sq_v[0] = ({{(SQW-1){1'b0}}, 1'b1} << 60) - s2[SQW-1:0];
  assign sq_r[0] = '0;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    q2e_sqrt_cell #(.K(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .v_in  (sq_v[k]),
      .r_in  (sq_r[k]),
      .v_out (sq_v[k+1]),
      .r_out (sq_r[k+1])
    );
  end

  // Quadrant pre-rotation for the three lanes: roll, pitch, yaw
  logic signed [XW-1:0]         lx [0:2][0:CORDIC_STAGES];
  logic signed [XW-1:0]         ly [0:2][0:CORDIC_STAGES];
  logic        [ANGLE_BITS-1:0] lz [0:2][0:CORDIC_STAGES];
  logic signed [XW-1:0]         rx [0:2];
  logic signed [XW-1:0]         ry [0:2];
  logic        [ANGLE_BITS-1:0] rz [0:2];
  logic        [4:0]            fl [0:CORDIC_STAGES];
  logic signed [XW-1:0]         ay [0:2];
  logic signed [XW-1:0]         ax [0:2];

  always_comb begin
    ay[0] = XW'(side[NSQ+1].sr);
    ax[0] = XW'(side[NSQ+1].cr);
    ay[1] = XW'(side[NSQ+1].sp);
    ax[1] = XW'($signed({1'b0, sq_r[NSQ][30:0]}));
    ay[2] = XW'(side[NSQ+1].sy);
    ax[2] = XW'(side[NSQ+1].cy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (ax[l][XW-1]) begin
          if (!ay[l][XW-1]) begin
            rx[l] <= ay[l];
            ry[l] <= -ax[l];
            rz[l] <= QUARTER;
          end else begin
            rx[l] <= -ay[l];
            ry[l] <= ax[l];
            rz[l] <= -QUARTER;
          end
        end else begin
          rx[l] <= ax[l];
          ry[l] <= ay[l];
          rz[l] <= '0;
        end
      end
      fl[0] <= {side[NSQ+1].sat_neg, side[NSQ+1].sat_pos,
                (ax[2] == '0) && (ay[2] == '0),
                (ax[1] == '0) && (ay[1] == '0),
                (ax[0] == '0) && (ay[0] == '0)};
      for (int s = 1; s <= CORDIC_STAGES; s++) fl[s] <= fl[s-1];
    end
  end

  // CORDIC rows
  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign lx[l][0] = rx[l];
    assign ly[l][0] = ry[l];
    assign lz[l][0] = rz[l];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      q2e_cordic_cell #(.ANGLE_BITS(ANGLE_BITS), .IDX(s)) u_cell (
        .clk   (clk),
        .en    (en),
        .x_in  (lx[l][s]),
        .y_in  (ly[l][s]),
        .z_in  (lz[l][s]),
        .x_out (lx[l][s+1]),
        .y_out (ly[l][s+1]),
        .z_out (lz[l][s+1])
      );
    end
  end

  // Reduce the phase to a 16-bit binary angle
  logic [15:0] ang [0:2];

  for (genvar l = 0; l < 3; l++) begin : g_reduce
    if (ANGLE_BITS > 16) begin : g_round
      logic [ANGLE_BITS-1:0] zr;
      assign zr = lz[l][CORDIC_STAGES] +
                  ({{(ANGLE_BITS-1){1'b0}}, 1'b1} << (ANGLE_BITS - 17));
      assign ang[l] = fl[CORDIC_STAGES][l] ? 16'd0 : zr[ANGLE_BITS-1:ANGLE_BITS-16];
    end else if (ANGLE_BITS == 16) begin : g_same
      assign ang[l] = fl[CORDIC_STAGES][l] ? 16'd0 : lz[l][CORDIC_STAGES][15:0];
    end else begin : g_shift
      assign ang[l] = fl[CORDIC_STAGES][l] ? 16'd0 :
                      {lz[l][CORDIC_STAGES], {(16-ANGLE_BITS){1'b0}}};
    end
  end

  // Limit pitch, apply saturation, hold the result
  logic signed [15:0] pitch;
  logic signed [15:0] pitch_lim;

  assign pitch = ang[1];

  always_comb begin
    if (fl[CORDIC_STAGES][3]) begin
      pitch_lim = 16'sd16384;
    end else if (fl[CORDIC_STAGES][4]) begin
      pitch_lim = -16'sd16384;
    end else if (pitch > 16'sd16384) begin
      pitch_lim = 16'sd16384;
    end else if (pitch < -16'sd16384) begin
      pitch_lim = -16'sd16384;
    end else begin
      pitch_lim = pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {ang[2], pitch_lim, ang[0]};
      m_tuser <= fl[CORDIC_STAGES][3] | fl[CORDIC_STAGES][4];
    end
  end

endmodule
`default_nettype wire

/* hdl/q2e_checker.sv */
`default_nettype none
module q2e_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [63:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tuser
);

  // Hold a stalled output transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output transaction dropped while stalled");

  // A clamped pitch sits exactly at plus or minus a quarter turn
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[31:16] == 16'h4000 || m_tdata[31:16] == 16'hC000))
    else $error("clamped pitch not at a quarter turn");

  // Pitch stays within a quarter turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384 &&
                  $signed(m_tdata[31:16]) >= -16'sd16384))
    else $error("pitch outside a quarter turn");

  // An empty output never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output empty");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind quaternion_to_euler_unit q2e_checker u_q2e_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
